// ----- rtl/core/s5mc_pkg.sv -----
// Shared types, constants and register codes for the separable 5x5 mirror filter.
package s5mc_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;
    localparam int ROW_SLOTS  = 8;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int SLOT_W  = $clog2(ROW_SLOTS);
    localparam int ADDR_W  = SLOT_W + COL_W;
    localparam int DEPTH   = ROW_SLOTS * MAX_WIDTH;
    localparam int FW_W    = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W   = $clog2(MAX_HEIGHT + 1);
    localparam int PEND_W  = $clog2(2 * MAX_WIDTH + 3);
    localparam int CMP_W   = 14;

    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 13;
    localparam int PIX_W        = 16;
    localparam int CFG_ADDR_W   = 5;

    localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd2048;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd1024;
    localparam logic [FW_W-1:0] FW_RESET =
        (MAX_WIDTH < 2048) ? FW_W'(MAX_WIDTH) : FW_W'(2048);

    // tap positions along one axis, far left to far right
    localparam logic [2:0] TAP_FAR_L  = 3'd0;
    localparam logic [2:0] TAP_NEAR_L = 3'd1;
    localparam logic [2:0] TAP_CENTER = 3'd2;
    localparam logic [2:0] TAP_NEAR_R = 3'd3;
    localparam logic [2:0] TAP_FAR_R  = 3'd4;

    localparam logic CMD_PIXEL = 1'b0;

    typedef enum logic [2:0] {
        REG_WIDTH     = 3'd0,
        REG_HEIGHT    = 3'd1,
        REG_H_CENTER  = 3'd2,
        REG_H_NEAR    = 3'd3,
        REG_H_FAR     = 3'd4,
        REG_V_CENTER  = 3'd5,
        REG_V_NEAR    = 3'd6,
        REG_V_FAR     = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_RUN,
        ST_WAIT
    } t_state;

    typedef struct packed {
        logic       valid;
        logic [2:0] row;
        logic [2:0] col;
    } t_tap;

    typedef struct packed {
        logic signed [PIX_W-1:0] hc;
        logic signed [PIX_W-1:0] hn;
        logic signed [PIX_W-1:0] hf;
        logic signed [PIX_W-1:0] vc;
        logic signed [PIX_W-1:0] vn;
        logic signed [PIX_W-1:0] vf;
    } t_weights;

endpackage

// ----- rtl/core/s5mc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module s5mc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/s5mc_mac.sv -----
// Multiply-accumulate pipeline: horizontal row sums, then the vertical sum.
module s5mc_mac (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  s5mc_pkg::t_tap                  i_tap,
    input  logic signed [s5mc_pkg::PIX_W-1:0] i_rdata,
    input  s5mc_pkg::t_weights              i_weights,
    output logic                            o_done,
    output logic [s5mc_pkg::PIX_W-1:0]      o_pixel
);
    import s5mc_pkg::*;

    function automatic logic signed [17:0] rnd_sat18(input logic signed [34:0] a);
        logic signed [34:0] s;
        s = (a + 35'sd16384) >>> 15;
        if (s > 35'sd131071) begin
            return 18'sh1FFFF;
        end else if (s < -35'sd131072) begin
            return 18'sh20000;
        end
        return s[17:0];
    endfunction

    function automatic logic signed [15:0] rnd_sat16(input logic signed [36:0] a);
        logic signed [36:0] s;
        s = (a + 37'sd16384) >>> 15;
        if (s > 37'sd32767) begin
            return 16'sh7FFF;
        end else if (s < -37'sd32768) begin
            return 16'sh8000;
        end
        return s[15:0];
    endfunction

    logic signed [PIX_W-1:0] hw;
    logic signed [PIX_W-1:0] vw;
    logic signed [31:0]      r_hp;
    t_tap                    r_tap2;
    logic signed [34:0]      r_hacc;
    logic signed [34:0]      hsum;
    logic signed [17:0]      r_hs;
    logic                    r_hs_valid;
    logic [2:0]              r_hs_row;
    logic signed [33:0]      r_vp;
    logic                    r_vp_valid;
    logic [2:0]              r_vp_row;
    logic signed [36:0]      r_vacc;
    logic signed [36:0]      vsum;
    logic                    r_done;
    logic [PIX_W-1:0]        r_pixel;

    always_comb begin
        case (i_tap.col) inside
            TAP_CENTER:             hw = i_weights.hc;
            TAP_NEAR_L, TAP_NEAR_R: hw = i_weights.hn;
            default:                hw = i_weights.hf;
        endcase
        case (r_hs_row) inside
            TAP_CENTER:             vw = i_weights.vc;
            TAP_NEAR_L, TAP_NEAR_R: vw = i_weights.vn;
            default:                vw = i_weights.vf;
        endcase
    end

    assign hsum = ((r_tap2.col == TAP_FAR_L) ? 35'sd0 : r_hacc) + 35'(r_hp);
    assign vsum = ((r_vp_row == TAP_FAR_L) ? 37'sd0 : r_vacc) + 37'(r_vp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap2     <= '0;
            r_hs_valid <= 1'b0;
            r_vp_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_tap2     <= i_tap;
            r_hs_valid <= r_tap2.valid && (r_tap2.col == TAP_FAR_R);
            r_vp_valid <= r_hs_valid;
            r_done     <= r_vp_valid && (r_vp_row == TAP_FAR_R);
        end
        r_hp <= 32'(hw) * 32'(i_rdata);
        if (r_tap2.valid) begin
            if (r_tap2.col == TAP_FAR_R) begin
                r_hs     <= rnd_sat18(hsum);
                r_hs_row <= r_tap2.row;
            end else begin
                r_hacc <= hsum;
            end
        end
        r_vp     <= 34'(vw) * 34'(r_hs);
        r_vp_row <= r_hs_row;
        if (r_vp_valid) begin
            if (r_vp_row == TAP_FAR_R) begin
                r_pixel <= rnd_sat16(vsum);
            end else begin
                r_vacc <= vsum;
            end
        end
    end

    assign o_done  = r_done;
    assign o_pixel = r_pixel;

endmodule

// ----- rtl/core/separable_5x5_mirror_convolution_core.sv -----
// Top level: stream control, row store, tap sequencer and configuration registers.
//
// Input stream (s side): tdata carries the pixel, tuser the command (pixel or
// drain). Output stream (m side): tdata carries the filtered pixel, tlast marks
// the last output of the frame. Each output belongs to the pixel that went in
// 2*W+2 items earlier; after a frame's last pixel, drain items (or further
// pixels) push out the rest, and drains before then are dropped.
// Each pixel of the frame is written to the row store in the cycle it is accepted;
// items after the frame's last pixel are not. An item that produces a result
// then runs a 25-read sequence on the row store's single read port, feeding a
// shared pipelined multiply-accumulate, and the result lands in the output
// register. Items without a result do not start the sequence. The 25 serial
// reads on one port set the rate: the next item waits until the result is back.
// The input is taken while a result waits in the output register; a following
// item that produces a result holds before its reads until the register is free,
// so a stalled receiver stops the input after at most one further
// result-producing item (items without a result are still taken).
// Reset clears counters and loads the register defaults; the row store is not
// cleared, and a frame reads only what it wrote.
module separable_5x5_mirror_convolution_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [s5mc_pkg::PIX_W-1:0]     i_s_tdata,   // [15:0] pixel_in
    input  logic                           i_s_tuser,   // [0] cmd
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [s5mc_pkg::PIX_W-1:0]     o_m_tdata,   // [15:0] pixel_out
    output logic                           o_m_tlast,   // frame_end
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [s5mc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import s5mc_pkg::*;

    localparam int MW = FW_W + 1;
    localparam int RW = ROW_W + 1;

    // configuration
    logic [CFG_WIDTH_W-1:0]  r_cfg_w;
    logic [CFG_HEIGHT_W-1:0] r_cfg_h;
    t_weights                r_wt;
    t_reg_idx                reg_idx;
    logic                    cfg_wr;

    // stream position
    logic [COL_W-1:0]  r_in_col, n_in_col, r_out_col, n_out_col, r_ec, n_ec;
    logic [ROW_W-1:0]  r_in_row, n_in_row, r_out_row, n_out_row, r_er, n_er;
    logic [PEND_W-1:0] r_pend, n_pend, lead;
    logic [FW_W-1:0]   r_fw, n_fw, fw_cl, fw_eff, oc_inc;
    logic [ROW_W-1:0]  r_fh, n_fh, fh_cl, fh_eff, or_inc;
    logic              r_end, n_end;
    logic              accept, flushing, frame_start, emit, wr_en;

    // sequencer
    t_state            r_state, n_state;
    logic [2:0]        r_dr, n_dr, r_dc, n_dc;
    logic              rd_en;
    t_tap              r_tap;
    logic [MW-1:0]     cx, cm;
    logic [RW-1:0]     rx, rm;
    logic [ADDR_W-1:0] raddr;
    logic [PIX_W-1:0]  rdata;

    // output register
    logic              r_m_valid;
    logic [PIX_W-1:0]  r_m_data;
    logic              r_m_last;
    logic              mac_done;
    logic [PIX_W-1:0]  mac_pixel;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= WIDTH_RESET;
            r_cfg_h <= HEIGHT_RESET;
            r_wt.hc <= 16'sd13107;
            r_wt.hn <= 16'sd8192;
            r_wt.hf <= 16'sd1638;
            r_wt.vc <= 16'sd13107;
            r_wt.vn <= 16'sd8192;
            r_wt.vf <= 16'sd1638;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_WIDTH:    r_cfg_w <= pwdata[CFG_WIDTH_W-1:0];
                REG_HEIGHT:   r_cfg_h <= pwdata[CFG_HEIGHT_W-1:0];
                REG_H_CENTER: r_wt.hc <= pwdata[PIX_W-1:0];
                REG_H_NEAR:   r_wt.hn <= pwdata[PIX_W-1:0];
                REG_H_FAR:    r_wt.hf <= pwdata[PIX_W-1:0];
                REG_V_CENTER: r_wt.vc <= pwdata[PIX_W-1:0];
                REG_V_NEAR:   r_wt.vn <= pwdata[PIX_W-1:0];
                REG_V_FAR:    r_wt.vf <= pwdata[PIX_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:    prdata = 32'(r_cfg_w);
            REG_HEIGHT:   prdata = 32'(r_cfg_h);
            REG_H_CENTER: prdata = {16'd0, r_wt.hc};
            REG_H_NEAR:   prdata = {16'd0, r_wt.hn};
            REG_H_FAR:    prdata = {16'd0, r_wt.hf};
            REG_V_CENTER: prdata = {16'd0, r_wt.vc};
            REG_V_NEAR:   prdata = {16'd0, r_wt.vn};
            REG_V_FAR:    prdata = {16'd0, r_wt.vf};
            default:      prdata = 32'd0;
        endcase
    end

    // ---------------- stream position update ----------------
    assign o_s_tready  = (r_state == ST_IDLE);
    assign accept      = i_s_tvalid && o_s_tready;
    assign flushing    = (r_in_row >= r_fh);
    assign frame_start = (r_in_row == '0) && (r_in_col == '0) && (r_pend == '0);

    assign fw_cl = (r_cfg_w < 12'd3) ? FW_W'(3) :
                   ((CMP_W'(r_cfg_w) > CMP_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH)
                                                          : FW_W'(r_cfg_w));
    assign fh_cl = (r_cfg_h < 13'd3) ? ROW_W'(3) :
                   ((CMP_W'(r_cfg_h) > CMP_W'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT)
                                                           : ROW_W'(r_cfg_h));

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_pend    = r_pend;
        n_fw      = r_fw;
        n_fh      = r_fh;
        n_ec      = r_ec;
        n_er      = r_er;
        n_end     = r_end;
        fw_eff    = r_fw;
        fh_eff    = r_fh;
        emit      = 1'b0;
        wr_en     = 1'b0;
        lead      = '0;
        oc_inc    = '0;
        or_inc    = '0;
        if (accept) begin
            if (flushing) begin
                emit = 1'b1;
            end else if (i_s_tuser == CMD_PIXEL) begin
                if (frame_start) begin
                    fw_eff = fw_cl;
                    fh_eff = fh_cl;
                end
                n_fw  = fw_eff;
                n_fh  = fh_eff;
                wr_en = 1'b1;
                if (FW_W'(r_in_col) + FW_W'(1) >= fw_eff) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + ROW_W'(1);
                end else begin
                    n_in_col = r_in_col + COL_W'(1);
                end
                lead = PEND_W'({fw_eff, 1'b0}) + PEND_W'(2);
                if (r_pend < lead) begin
                    n_pend = r_pend + PEND_W'(1);
                end else begin
                    emit = 1'b1;
                end
            end
            if (emit) begin
                n_ec   = r_out_col;
                n_er   = r_out_row;
                oc_inc = FW_W'(r_out_col) + FW_W'(1);
                or_inc = r_out_row;
                if (oc_inc >= fw_eff) begin
                    n_out_col = '0;
                    or_inc    = r_out_row + ROW_W'(1);
                end else begin
                    n_out_col = oc_inc[COL_W-1:0];
                end
                n_out_row = or_inc;
                n_end     = 1'b0;
                if (or_inc >= fh_eff) begin
                    // frame complete: back to the start position
                    n_end     = 1'b1;
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                    n_pend    = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_pend    <= '0;
            r_fw      <= FW_RESET;
            r_fh      <= ROW_W'(HEIGHT_RESET);
            r_end     <= 1'b0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_pend    <= n_pend;
            r_fw      <= n_fw;
            r_fh      <= n_fh;
            r_end     <= n_end;
        end
        r_ec <= n_ec;
        r_er <= n_er;
    end

    // ---------------- tap sequencer ----------------
    always_comb begin
        n_state = r_state;
        n_dr    = r_dr;
        n_dc    = r_dc;
        rd_en   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_dr = TAP_FAR_L;
                n_dc = TAP_FAR_L;
                if (emit) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                // output register must be free before the result comes back
                if (!r_m_valid || i_m_tready) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                rd_en = 1'b1;
                if (r_dc == TAP_FAR_R) begin
                    n_dc = TAP_FAR_L;
                    n_dr = r_dr + 3'd1;
                    if (r_dr == TAP_FAR_R) begin
                        n_state = ST_WAIT;
                    end
                end else begin
                    n_dc = r_dc + 3'd1;
                end
            end
            ST_WAIT: begin
                if (mac_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dr    <= TAP_FAR_L;
            r_dc    <= TAP_FAR_L;
            r_tap   <= '0;
        end else begin
            r_state   <= n_state;
            r_dr      <= n_dr;
            r_dc      <= n_dc;
            r_tap.valid <= rd_en;
            r_tap.row   <= r_dr;
            r_tap.col   <= r_dc;
        end
    end

    // mirrored read position, offset by two: below two folds back, past the
    // edge folds in with the edge sample repeated
    always_comb begin
        cx = MW'(r_ec) + MW'(r_dc);
        if (cx < MW'(2)) begin
            cm = MW'(1) - cx;
        end else if (cx >= MW'(r_fw) + MW'(2)) begin
            cm = (MW'(r_fw) << 1) + MW'(1) - cx;
        end else begin
            cm = cx - MW'(2);
        end
        rx = RW'(r_er) + RW'(r_dr);
        if (rx < RW'(2)) begin
            rm = RW'(1) - rx;
        end else if (rx >= RW'(r_fh) + RW'(2)) begin
            rm = (RW'(r_fh) << 1) + RW'(1) - rx;
        end else begin
            rm = rx - RW'(2);
        end
    end

    assign raddr = {rm[SLOT_W-1:0], cm[COL_W-1:0]};

    s5mc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr ({r_in_row[SLOT_W-1:0], r_in_col}),
        .i_wdata (i_s_tdata),
        .i_re    (rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    s5mc_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tap     (r_tap),
        .i_rdata   (rdata),
        .i_weights (r_wt),
        .o_done    (mac_done),
        .o_pixel   (mac_pixel)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (mac_done) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
        if (mac_done) begin
            r_m_data <= mac_pixel;
            r_m_last <= r_end;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

    // ---------------- assertions ----------------
    a_done_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mac_done |-> (r_state == ST_WAIT) && !r_m_valid)
        else $error("result arrived with output register occupied");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_row <= r_fh)
        else $error("input row ran past frame height");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PEND_W'({r_fw, 1'b0}) + PEND_W'(2))
        else $error("lead-in count exceeds its limit");

    a_run_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) && (r_dr == TAP_FAR_R) && (r_dc == TAP_FAR_R)
            |=> (r_state == ST_WAIT))
        else $error("sequencer left the read phase early or late");

endmodule
